/* rtl/core/owrt_pkg.sv */
package owrt_pkg;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_DUP      = 3'd1;
   localparam logic [2:0] STATUS_NOTFOUND = 3'd2;
   localparam logic [2:0] STATUS_FULL     = 3'd3;
   localparam logic [2:0] STATUS_BADACT   = 3'd4;

   localparam logic [1:0] CMD_NONE   = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;
   localparam logic [1:0] CMD_BUMP   = 2'd3;

   localparam logic [31:0] WILDCARD = 32'hFFFF_FFFF;
   localparam logic [31:0] HITS_MAX = 32'hFFFF_FFFF;
   localparam logic [2:0]  ACT_MAX  = 3'd1;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] rule_number;
      logic [31:0] requester_id;
      logic [31:0] target_id;
      logic [2:0]  allow_action;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        decision;
      logic        matched;
      logic [31:0] hit_count;
   } rsp_type;

   typedef struct packed {
      logic [15:0] number;
      logic [31:0] requester;
      logic [31:0] target;
      logic        allow;
      logic [31:0] hits;
   } entry_type;

   // The search wave that walks along the chain, one cell per cycle.
   typedef struct packed {
      logic        live;
      logic        found;
      logic        dup;
      logic        allow;
      logic [31:0] hits;
   } token_type;

   typedef struct packed {
      logic       apply;
      logic [1:0] cmd;
   } ctl_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] value);
      return (value == HITS_MAX) ? value : value + 32'd1;
   endfunction

endpackage

/* rtl/core/ordered_wildcard_rule_table_unit.sv */
// Channel | Ports                          | Transfer when
// --------+--------------------------------+------------------------
// request | req_valid, req_ready, req_data | req_valid && req_ready
// result  | rsp_valid, rsp_ready, rsp_data | rsp_valid && rsp_ready
//
// One item at a time: a request is taken only while the unit is idle. After the
// search wave has stepped through the row of rule cells, one per cycle, the
// result is registered with the update once the result slot is free.
// The table is updated once after the wave: a shift, or a hit bump on lookup.
// Reset empties the table at once; the cell contents themselves are not reset.
// A held result does not stop a new request; the update waits for the slot.
module ordered_wildcard_rule_table_unit
   import owrt_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int CNT_W = $clog2(ENTRIES + 1);

   req_type          key;
   logic [CNT_W-1:0] used;
   ctl_type          ctl;
   token_type        tok   [ENTRIES+1];
   entry_type        ent   [ENTRIES];
   logic             mark  [ENTRIES];

   owrt_ctrl #(
      .ENTRIES(ENTRIES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .key       (key),
      .used      (used),
      .tok_start (tok[0]),
      .tok_end   (tok[ENTRIES]),
      .ctl       (ctl)
   );

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      entry_type left_ent;
      logic      left_mark;
      entry_type right_ent;

      if (i == 0) begin : g_first
         assign left_ent  = '0;
         assign left_mark = 1'b0;
      end else begin : g_inner
         assign left_ent  = ent[i-1];
         assign left_mark = mark[i-1];
      end

      if (i == ENTRIES - 1) begin : g_last
         assign right_ent = ent[i];
      end else begin : g_body
         assign right_ent = ent[i+1];
      end

      owrt_cell #(
         .ENTRIES(ENTRIES),
         .INDEX  (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .key       (key),
         .used      (used),
         .ctl       (ctl),
         .tok_in    (tok[i]),
         .tok_out   (tok[i+1]),
         .left_ent  (left_ent),
         .left_mark (left_mark),
         .right_ent (right_ent),
         .ent_out   (ent[i]),
         .mark_out  (mark[i])
      );
   end

endmodule

/* rtl/core/owrt_cell.sv */
module owrt_cell
   import owrt_pkg::*;
#(
   parameter int ENTRIES = 16,
   parameter int INDEX   = 0,
   localparam int CNT_W  = $clog2(ENTRIES + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  req_type          key,
   input  logic [CNT_W-1:0] used,
   input  ctl_type          ctl,
   input  token_type        tok_in,
   output token_type        tok_out,
   input  entry_type        left_ent,
   input  logic             left_mark,
   input  entry_type        right_ent,
   output entry_type        ent_out,
   output logic             mark_out
);

   entry_type ent_ff;
   token_type tok_ff;
   token_type tok_in_next;
   logic      mark_ff;
   logic      mark_in;

   logic occ;
   logic req_hit;
   logic tgt_hit;
   logic is_match;
   logic is_dup;
   logic num_gt;
   logic num_eq;
   entry_type new_ent;

   assign occ      = CNT_W'(INDEX) < used;
   assign req_hit  = (ent_ff.requester == key.requester_id) || (ent_ff.requester == WILDCARD);
   assign tgt_hit  = (ent_ff.target == key.target_id) || (ent_ff.target == WILDCARD);
   assign is_match = occ && req_hit && tgt_hit;
   assign num_gt   = occ && (ent_ff.number > key.rule_number);
   assign num_eq   = occ && (ent_ff.number == key.rule_number);
   assign is_dup   = num_eq && (ent_ff.requester == key.requester_id)
                     && (ent_ff.target == key.target_id)
                     && (ent_ff.allow == key.allow_action[0]);

   always_comb begin
      new_ent.number    = key.rule_number;
      new_ent.requester = key.requester_id;
      new_ent.target    = key.target_id;
      new_ent.allow     = key.allow_action[0];
      new_ent.hits      = '0;
   end

   // The mark says whether this cell takes part in the update that follows the
   // scan: for an add, every cell from the insertion point onwards shifts up.
   always_comb begin
      tok_in_next = tok_in;
      mark_in     = 1'b0;
      unique case (key.opcode)
         OP_ADD: begin
            mark_in           = tok_in.found || !occ || num_gt;
            tok_in_next.found = mark_in;
            tok_in_next.dup   = tok_in.dup || is_dup;
         end
         OP_DELETE: begin
            mark_in           = tok_in.found || num_eq;
            tok_in_next.found = mark_in;
         end
         OP_LOOKUP: begin
            mark_in = !tok_in.found && is_match;
            if (mark_in) begin
               tok_in_next.found = 1'b1;
               tok_in_next.allow = ent_ff.allow;
               tok_in_next.hits  = sat_inc(ent_ff.hits);
            end
         end
         default: begin
            mark_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff  <= '0;
         mark_ff <= 1'b0;
      end else begin
         tok_ff <= tok_in_next;
         if (tok_in.live) begin
            mark_ff <= mark_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.apply && mark_ff) begin
         case (ctl.cmd)
            CMD_INSERT: ent_ff <= left_mark ? left_ent : new_ent;
            CMD_REMOVE: ent_ff <= right_ent;
            CMD_BUMP:   ent_ff.hits <= sat_inc(ent_ff.hits);
            default:    ent_ff <= ent_ff;
         endcase
      end
   end

   assign tok_out  = tok_ff;
   assign ent_out  = ent_ff;
   assign mark_out = mark_ff;

endmodule

/* rtl/core/owrt_ctrl.sv */
module owrt_ctrl
   import owrt_pkg::*;
#(
   parameter int ENTRIES = 16,
   localparam int CNT_W  = $clog2(ENTRIES + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   output req_type          key,
   output logic [CNT_W-1:0] used,
   output token_type        tok_start,
   input  token_type        tok_end,
   output ctl_type          ctl
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_APPLY = 2'd2;

   logic [1:0]       state_ff;
   logic             start_ff;
   req_type          key_ff;
   token_type        sum_ff;
   logic [CNT_W-1:0] used_ff;
   logic [CNT_W-1:0] used_in;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;
   logic [1:0]       cmd;
   logic             slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_in  = '0;
      cmd     = CMD_NONE;
      used_in = used_ff;
      unique case (key_ff.opcode)
         OP_ADD: begin
            if (key_ff.allow_action > ACT_MAX) begin
               rsp_in.status = STATUS_BADACT;
            end else if (used_ff == CNT_W'(ENTRIES)) begin
               rsp_in.status = STATUS_FULL;
            end else if (sum_ff.dup) begin
               rsp_in.status = STATUS_DUP;
            end else begin
               cmd     = CMD_INSERT;
               used_in = used_ff + CNT_W'(1);
            end
         end
         OP_DELETE: begin
            if (sum_ff.found) begin
               cmd     = CMD_REMOVE;
               used_in = used_ff - CNT_W'(1);
            end else begin
               rsp_in.status = STATUS_NOTFOUND;
            end
         end
         OP_LOOKUP: begin
            if (sum_ff.found) begin
               cmd              = CMD_BUMP;
               rsp_in.matched   = 1'b1;
               rsp_in.decision  = sum_ff.allow;
               rsp_in.hit_count = sum_ff.hits;
            end
         end
         default: begin
            cmd = CMD_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= 1'b0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff <= (state_ff == S_IDLE) && req_valid;
         if (state_ff == S_APPLY && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (tok_end.live) begin
                  state_ff <= S_APPLY;
               end
            end
            S_APPLY: begin
               if (slot_free) begin
                  used_ff  <= used_in;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         key_ff <= req_data;
      end
      if (state_ff == S_SCAN && tok_end.live) begin
         sum_ff <= tok_end;
      end
      if (state_ff == S_APPLY && slot_free) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      tok_start      = '0;
      tok_start.live = start_ff;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign key       = key_ff;
   assign used      = used_ff;
   assign ctl       = {(state_ff == S_APPLY) && slot_free, cmd};

endmodule

/* rtl/core/owrt_checker.sv */
module owrt_checker
   import owrt_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A stalled result keeps its value until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Items are worked one at a time, so a request transfer closes the input.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is at work");

   // A result without a matched rule carries no decision and no count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.matched |-> !rsp_data.decision && rsp_data.hit_count == '0)
      else $error("unmatched result with decision or count");

   // A match always comes with success and a count of at least one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.matched
         |-> rsp_data.status == STATUS_OK && rsp_data.hit_count != '0)
      else $error("matched result with bad status or zero count");

endmodule

bind ordered_wildcard_rule_table_unit owrt_checker u_checker (.*);
